### sv/gfpe_pkg.sv
// shared constants, types and helpers of the gf(2^8) erasure parity encoder
// no dependencies; imported by every module of the block
`default_nettype none

package gfpe_pkg;

    localparam int SRC_BYTES          = 5;
    localparam int ROW_COUNT          = 6;
    localparam int SRC_W              = 8 * SRC_BYTES;
    localparam int CODED_W            = 8 * ROW_COUNT;
    localparam int CFG_W              = 40;
    localparam int CFG_IDX_W          = 3;
    localparam int BITS_PER_STAGE     = 2;
    localparam int STAGES             = 8 / BITS_PER_STAGE;
    localparam int SOURCE_SYMBOLS_DEF = 5;
    localparam int CODED_PACKETS_DEF  = 6;

    localparam logic [7:0] POLY_RESET = 8'h1D;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_ROW_0    = 3'd0,
        REG_COEFF_ROW_1    = 3'd1,
        REG_COEFF_ROW_2    = 3'd2,
        REG_COEFF_ROW_3    = 3'd3,
        REG_COEFF_ROW_4    = 3'd4,
        REG_COEFF_ROW_5    = 3'd5,
        REG_REDUCTION_POLY = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_COUNT-1:0][SRC_BYTES-1:0][7:0] coeff;
        logic [7:0]                               poly;
    } gfpe_cfg_t;

    // multiply by x modulo x^8 + poly
    function automatic logic [7:0] gf_xtime(input logic [7:0] x, input logic [7:0] poly);
        logic [7:0] sh;
        sh = {x[6:0], 1'b0};
        return x[7] ? (sh ^ poly) : sh;
    endfunction

endpackage

`default_nettype wire

### sv/gfpe_cfg_regs.sv
// configuration registers: six coefficient rows and the reduction polynomial
// depends on gfpe_pkg
`default_nettype none

module gfpe_cfg_regs
    import gfpe_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output gfpe_cfg_t                 cfg
);

    gfpe_cfg_t cfg_reg;
    gfpe_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COEFF_ROW_0:    cfg_next.coeff[0] = cfg_data;
                REG_COEFF_ROW_1:    cfg_next.coeff[1] = cfg_data;
                REG_COEFF_ROW_2:    cfg_next.coeff[2] = cfg_data;
                REG_COEFF_ROW_3:    cfg_next.coeff[3] = cfg_data;
                REG_COEFF_ROW_4:    cfg_next.coeff[4] = cfg_data;
                REG_COEFF_ROW_5:    cfg_next.coeff[5] = cfg_data;
                REG_REDUCTION_POLY: cfg_next.poly     = cfg_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coeff <= '0;
            cfg_reg.poly  <= POLY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### sv/gfpe_stage.sv
// one pipeline stage of the shift-and-xor gf(2^8) multiply-accumulate
// handles BITS_PER_STAGE source bits for every packet/source pair; depends on gfpe_pkg
`default_nettype none

module gfpe_stage
    import gfpe_pkg::*;
#(
    parameter int NS        = SOURCE_SYMBOLS_DEF,
    parameter int CP        = CODED_PACKETS_DEF,
    parameter int FIRST_BIT = 0
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [7:0]                   poly,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [CP-1:0][NS-1:0][7:0]   in_x,
    input  wire logic [CP-1:0][7:0]           in_acc,
    input  wire logic [NS-1:0][7:0]           in_src,
    input  wire logic                         in_last,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [CP-1:0][NS-1:0][7:0]        out_x,
    output logic [CP-1:0][7:0]                out_acc,
    output logic [NS-1:0][7:0]                out_src,
    output logic                              out_last
);

    logic                       valid_reg;
    logic [CP-1:0][NS-1:0][7:0] x_reg;
    logic [CP-1:0][NS-1:0][7:0] x_next;
    logic [CP-1:0][7:0]         acc_reg;
    logic [CP-1:0][7:0]         acc_next;
    logic [NS-1:0][7:0]         src_reg;
    logic                       last_reg;
    logic                       load;

    // stage moves when empty or when the next stage takes its transaction
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        x_next   = in_x;
        acc_next = in_acc;
        for (int b = 0; b < BITS_PER_STAGE; b++)
        begin
            for (int i = 0; i < CP; i++)
            begin
                for (int j = 0; j < NS; j++)
                begin
                    if (in_src[j][FIRST_BIT + b])
                    begin
                        acc_next[i] = acc_next[i] ^ x_next[i][j];
                    end
                    x_next[i][j] = gf_xtime(x_next[i][j], poly);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg    <= x_next;
            acc_reg  <= acc_next;
            src_reg  <= in_src;
            last_reg <= in_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_acc   = acc_reg;
    assign out_src   = src_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

### sv/gf256_erasure_parity_encoder.sv
// gf(2^8) erasure parity encoder, top level
// depends on gfpe_pkg, gfpe_cfg_regs and gfpe_stage
//
// Each input transaction carries one byte column: the byte at one position of
// every source symbol. For each coded packet i the block returns the xor over
// sources j of coeff[i][j] * src[j] in GF(2^8) modulo x^8 + reduction_poly,
// all packets packed into one output transaction, with tlast passed through.
// Throughput is one transaction per clock while the output is not stalled.
// The multiply is split into four register stages of two source bits each
// (shift-and-xor, products folded straight into the per-packet sums). The
// last stage is the output register, and each stage frees itself when empty
// or when its successor takes its transaction, so bubbles close up and a
// stall on the output side loses nothing.
// Configuration (coefficient rows 0..5 at index 0..5, polynomial at index 6)
// is written through cfg_we/cfg_index/cfg_data while no transaction is in
// flight; writes to index 7 are ignored. Coefficient rows reset to zero and
// the polynomial to 0x1D. Source bytes beyond the five in s_tdata read as
// zero, and packet bytes at or above CODED_PACKETS come out zero.
`default_nettype none

module gf256_erasure_parity_encoder
    import gfpe_pkg::*;
#(
    parameter int SOURCE_SYMBOLS = SOURCE_SYMBOLS_DEF,
    parameter int CODED_PACKETS  = CODED_PACKETS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [SRC_W-1:0]     s_tdata,    // source_bytes[39:0]
    input  wire logic                 s_tlast,    // last_byte
    // output stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [CODED_W-1:0]        m_tdata,    // coded_bytes[47:0]
    output logic                      m_tlast     // last_out
);

    // sources past the input word contribute nothing, so they get no lanes
    localparam int NS = (SOURCE_SYMBOLS < SRC_BYTES) ? SOURCE_SYMBOLS : SRC_BYTES;
    localparam int CP = CODED_PACKETS;

    gfpe_cfg_t cfg;

    logic [STAGES:0]            stg_valid;
    logic [STAGES:0]            stg_ready;
    logic [CP-1:0][NS-1:0][7:0] stg_x    [0:STAGES-1];
    logic [NS-1:0][7:0]         stg_src  [0:STAGES-1];
    logic [CP-1:0][7:0]         stg_acc  [0:STAGES];
    logic                       stg_last [0:STAGES];

    gfpe_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage 0 input: multiplicands start as the coefficients, sums start at zero
    always_comb
    begin
        for (int i = 0; i < CP; i++)
        begin
            for (int j = 0; j < NS; j++)
            begin
                stg_x[0][i][j] = cfg.coeff[i][j];
            end
            stg_acc[0][i] = 8'h00;
        end
        for (int j = 0; j < NS; j++)
        begin
            stg_src[0][j] = s_tdata[8*j +: 8];
        end
    end

    assign stg_last[0]       = s_tlast;
    assign stg_valid[0]      = s_tvalid;
    assign s_tready          = stg_ready[0];
    assign stg_ready[STAGES] = m_tready;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        if (k < STAGES - 1)
        begin : g_mid
            gfpe_stage #(
                .NS        (NS),
                .CP        (CP),
                .FIRST_BIT (k * BITS_PER_STAGE)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .poly      (cfg.poly),
                .in_valid  (stg_valid[k]),
                .in_ready  (stg_ready[k]),
                .in_x      (stg_x[k]),
                .in_acc    (stg_acc[k]),
                .in_src    (stg_src[k]),
                .in_last   (stg_last[k]),
                .out_valid (stg_valid[k+1]),
                .out_ready (stg_ready[k+1]),
                .out_x     (stg_x[k+1]),
                .out_acc   (stg_acc[k+1]),
                .out_src   (stg_src[k+1]),
                .out_last  (stg_last[k+1])
            );
        end
        else
        begin : g_last
            // final stage doubles as the output register
            gfpe_stage #(
                .NS        (NS),
                .CP        (CP),
                .FIRST_BIT (k * BITS_PER_STAGE)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .poly      (cfg.poly),
                .in_valid  (stg_valid[k]),
                .in_ready  (stg_ready[k]),
                .in_x      (stg_x[k]),
                .in_acc    (stg_acc[k]),
                .in_src    (stg_src[k]),
                .in_last   (stg_last[k]),
                .out_valid (stg_valid[k+1]),
                .out_ready (stg_ready[k+1]),
                .out_x     (),
                .out_acc   (stg_acc[k+1]),
                .out_src   (),
                .out_last  (stg_last[k+1])
            );
        end
    end

    // pack the coded bytes; unused packet slots stay zero
    always_comb
    begin
        m_tdata = '0;
        for (int i = 0; i < CP; i++)
        begin
            m_tdata[8*i +: 8] = stg_acc[STAGES][i];
        end
    end

    assign m_tvalid = stg_valid[STAGES];
    assign m_tlast  = stg_last[STAGES];

endmodule

`default_nettype wire

### sv/gfpe_checker.sv
// port-level checks of the gf(2^8) erasure parity encoder, bound to the top level
// depends on gfpe_pkg and gf256_erasure_parity_encoder
`default_nettype none

module gfpe_checker
    import gfpe_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [SRC_W-1:0]   s_tdata,
    input wire logic               s_tlast,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [CODED_W-1:0] m_tdata,
    input wire logic               m_tlast
);

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    // input only backs up once every stage is full and the output is stalled
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with room in the pipeline");

    // with the output free, each accepted transaction comes out with its tlast
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid && (m_tlast == $past(s_tlast, 4)))
        else $error("transaction lost or tlast not carried through");

    // an all-zero column codes to all zeros whatever the coefficients
    a_zero_column: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata == '0) ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tdata == '0)
        else $error("zero column gave nonzero coded bytes");

endmodule

bind gf256_erasure_parity_encoder gfpe_checker u_gfpe_checker (.*);

`default_nettype wire

### test/gfpe_parity_checker.sv
// checker for the gf(2^8) erasure parity encoder: watches config, input and output channels
// depends on gfpe_pkg; keeps its own copy of the coefficient rows and polynomial
module gfpe_parity_checker
    import gfpe_pkg::*;
#(
    parameter int SOURCE_SYMBOLS = SOURCE_SYMBOLS_DEF,
    parameter int CODED_PACKETS  = CODED_PACKETS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [SRC_W-1:0]     s_tdata,    // source_bytes[39:0]
    input  logic                 s_tlast,    // last_byte
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [CODED_W-1:0]   m_tdata,    // coded_bytes[47:0]
    input  logic                 m_tlast,    // last_out
    output int                   outstanding,
    output int                   failures,
    output int                   columns_checked
);

    typedef struct packed {
        logic [CODED_W-1:0] coded;
        logic               last;
    } coded_column_t;

    logic [CFG_W-1:0] coeff_rows [ROW_COUNT];
    logic [7:0]       field_poly;
    coded_column_t    expected_columns [$];

    // shift-and-xor product modulo x^8 + poly
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] poly);
        logic [7:0] acc;
        logic [7:0] x;
        acc = '0;
        x   = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
                acc ^= x;
            x = x[7] ? ({x[6:0], 1'b0} ^ poly) : {x[6:0], 1'b0};
        end
        return acc;
    endfunction

    function automatic logic [CODED_W-1:0] parity_column(input logic [SRC_W-1:0] src);
        logic [CODED_W-1:0] col;
        logic [7:0]         sum;
        logic [7:0]         coeff;
        logic [7:0]         data;
        col = '0;
        for (int i = 0; i < ROW_COUNT && i < CODED_PACKETS; i++)
        begin
            sum = '0;
            for (int j = 0; j < SOURCE_SYMBOLS && j < 8; j++)
            begin
                // sources past the five carried bytes read as zero
                coeff = (j < SRC_BYTES) ? coeff_rows[i][8*j +: 8] : 8'h00;
                data  = (j < SRC_BYTES) ? src[8*j +: 8] : 8'h00;
                sum ^= gf_product(coeff, data, field_poly);
            end
            col[8*i +: 8] = sum;
        end
        return col;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROW_COUNT; i++)
                coeff_rows[i] = '0;
            field_poly = POLY_RESET;
            expected_columns.delete();
            outstanding     <= 0;
            failures        = 0;
            columns_checked = 0;
        end
        else
        begin
            coded_column_t want;
            if (cfg_we)
            begin
                if (cfg_index < ROW_COUNT)
                    coeff_rows[cfg_index] = cfg_data;
                else if (cfg_index == REG_REDUCTION_POLY)
                    field_poly = cfg_data[7:0];
            end
            if (s_tvalid && s_tready)
                expected_columns.push_back('{coded: parity_column(s_tdata), last: s_tlast});
            if (m_tvalid && m_tready)
            begin
                if (expected_columns.size() == 0)
                begin
                    $error("output transaction with nothing expected: coded_bytes %h", m_tdata);
                    failures++;
                end
                else
                begin
                    want = expected_columns.pop_front();
                    columns_checked++;
                    if (m_tdata !== want.coded)
                    begin
                        $error("coded_bytes mismatch: expected %h, actual %h",
                               want.coded, m_tdata);
                        failures++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_out mismatch: expected %b, actual %b", want.last, m_tlast);
                        failures++;
                    end
                end
            end
            outstanding <= expected_columns.size();
        end
    end

endmodule

### test/gf256_erasure_parity_encoder_test.sv
// testbench top for the gf(2^8) erasure parity encoder: stimulus, idling and verdict
// depends on gfpe_pkg, gf256_erasure_parity_encoder and gfpe_parity_checker
module gf256_erasure_parity_encoder_test;
    import gfpe_pkg::*;

    // write port index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    // well above the slowest run: ~860 columns with heavy stalls plus config loads
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PHASES = 6;
    localparam int COLUMNS_PER_PHASE = 140;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [SRC_W-1:0]     s_tdata;    // source_bytes[39:0]
    logic                 s_tlast;    // last_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [CODED_W-1:0]   m_tdata;    // coded_bytes[47:0]
    logic                 m_tlast;    // last_out

    int outstanding;
    int failures;
    int columns_checked;
    int cycle_count;
    int settings_loaded;
    int src_idle_pct;
    int dst_idle_pct;

    // settings staged here before a load
    logic [CFG_W-1:0] rows [ROW_COUNT];
    logic [7:0]       poly;

    gf256_erasure_parity_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    gfpe_parity_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .outstanding     (outstanding),
        .failures        (failures),
        .columns_checked (columns_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d columns still expected",
                     cycle_count, outstanding);
            $display("[gf256_erasure_parity_encoder] ERROR");
            $finish;
        end
    end

    // receiver side: back-pressure drawn fresh every cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= dst_idle_pct);

    // byte biased toward the values that stress the field arithmetic
    function automatic logic [7:0] random_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [SRC_W-1:0] random_word();
        logic [SRC_W-1:0] w;
        for (int j = 0; j < SRC_BYTES; j++)
            w[8*j +: 8] = random_byte();
        return w;
    endfunction

    // one transaction on the input stream; valid stays high across back-to-back columns
    task automatic send_column(input logic [SRC_W-1:0] data, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // drop valid, let every expected column come back, then let the pipe settle
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // writes the staged rows and polynomial, plus a junk write to the unused index
    task automatic load_settings();
        for (int i = 0; i < ROW_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= rows[i];
            @(posedge clk);
        end
        cfg_index <= REG_REDUCTION_POLY;
        cfg_data  <= CFG_W'({$urandom, $urandom}) & ~CFG_W'(8'hFF) | CFG_W'(poly);
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= random_word();
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        m_tready        = 1'b0;
        settings_loaded = 0;
        src_idle_pct    = 24;
        dst_idle_pct    = 60;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: all coefficients zero, so every coded byte is zero
        send_column('0, 1'b0);
        send_column('1, 1'b1);
        drain_pipeline();

        // directed rows: plain xor, all-ones, times x, walking powers, zero row, mixed
        rows[0] = 40'h01_01_01_01_01;
        rows[1] = '1;
        rows[2] = 40'h00_00_00_00_02;
        rows[3] = 40'h80_40_20_10_08;
        rows[4] = '0;
        rows[5] = 40'hFF_01_FF_01_FF;
        poly    = POLY_RESET;
        load_settings();
        send_column('0, 1'b0);
        send_column('1, 1'b1);
        // high bit of each source alone, so every product with a coefficient above one goes through the reduction
        for (int j = 0; j < SRC_BYTES; j++)
            send_column(SRC_W'(8'h80) << (8 * j), j[0]);
        send_column(40'h01_02_04_08_10, 1'b0);
        send_column(40'hA5_5A_C3_3C_7E, 1'b1);
        send_column(40'h80_80_80_80_80, 1'b0);
        drain_pipeline();

        // polynomial extremes, including reducible ones, with all-ones coefficients but 0x80 in row 2
        for (int p = 0; p < 2; p++)
        begin
            for (int i = 0; i < ROW_COUNT; i++)
                rows[i] = '1;
            rows[2] = 40'h80_80_80_80_80;
            poly    = (p == 0) ? 8'h00 : 8'hFF;
            load_settings();
            send_column('1, 1'b0);
            send_column(40'h80_80_80_80_80, 1'b1);
            send_column(40'h01_02_04_08_10, 1'b0);
            drain_pipeline();
        end

        // random phases: new settings each, idling per phase pair
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            src_idle_pct = (ph < 2) ? 24 : (ph < 4) ? 60 : 0;
            dst_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 24 : 0;
            for (int i = 0; i < ROW_COUNT; i++)
            begin
                case ($urandom_range(9))
                    0:       rows[i] = '0;
                    1:       rows[i] = '1;
                    default: rows[i] = random_word();
                endcase
            end
            case ($urandom_range(5))
                0:       poly = 8'h00;
                1:       poly = 8'hFF;
                2:       poly = POLY_RESET;
                3:       poly = 8'h1B;
                default: poly = 8'($urandom);
            endcase
            load_settings();
            for (int n = 0; n < COLUMNS_PER_PHASE; n++)
                send_column(random_word(), $urandom_range(7) == 0);
            drain_pipeline();
        end

        $display("checked %0d byte columns under %0d coefficient and polynomial settings",
                 columns_checked, settings_loaded);
        $display("stalls: sender/receiver at 24/60, 60/24 and 0/0 percent, %0d failures",
                 failures);
        if (failures == 0)
            $display("[gf256_erasure_parity_encoder] OK");
        else
            $display("[gf256_erasure_parity_encoder] ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/gfpe_pkg.sv
sv/gfpe_cfg_regs.sv
sv/gfpe_stage.sv
sv/gf256_erasure_parity_encoder.sv
sv/gfpe_checker.sv
test/gfpe_parity_checker.sv
test/gf256_erasure_parity_encoder_test.sv
